>>> hw/rtl/bitmap_set_get_find_first_core_defines.svh
// Assertion macros shared by the bitmap core checkers.
// Needs a clock i_clk and an active-low reset i_rst_n in the using scope.
`ifndef BITMAP_SET_GET_FIND_FIRST_CORE_DEFINES_SVH
`define BITMAP_SET_GET_FIND_FIRST_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define BMFF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BMFF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/bmff_pkg.sv
// Shared types, sizes and helpers for the bitmap set/get/find-first core.
// No dependencies; used by the core (also to size its RAM) and the checker.
`default_nettype none

package bmff_pkg;

    // Map geometry
    localparam int MAP_BYTES = 64;
    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = $clog2(MAP_BYTES);
    localparam int POS_W     = $clog2(BYTE_W);
    localparam int CNT_W     = 7;
    localparam int IDX_W     = 9;
    localparam int ACT_W     = 2;
    localparam int TDATA_W   = 16;

    // Requested operation
    typedef enum logic [ACT_W-1:0] {
        ACT_FILL  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_FIND  = 2'd3
    } t_action;

    // Control sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_RMW,
        ST_FIND,
        ST_DONE
    } t_state;

    // Result of scanning one byte
    typedef struct packed {
        logic             hit;
        logic [POS_W-1:0] pos;
    } t_match;

    // Lowest bit position in a byte that equals the searched value
    function automatic t_match lowest_match(input logic [BYTE_W-1:0] data,
                                            input logic              val);
        t_match m;
        m.hit = 1'b0;
        m.pos = '0;
        for (int j = BYTE_W - 1; j >= 0; j--) begin
            if (data[j] == val) begin
                m.hit = 1'b1;
                m.pos = POS_W'(j);
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/bitmap_set_get_find_first_core.sv
// Bitmap core: byte-wide map in a RAM with fill, bit write, bit read and find-first.
// Depends on bmff_pkg and bmff_ram.
//
//  channel   | dir | handshake                      | beat contents
//  ----------+-----+--------------------------------+-----------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready  | action, bit_index, bit_value
//  m_axis    | out | m_axis_tvalid / m_axis_tready  | accepted, bit_read, first_found,
//            |     |                                | first_index
//  cfg       | in  | i_cfg_we (no wait)             | byte_count
//
// One command at a time. An in-range bit write or read passes RAM read, modify or extract,
// and result; an out-of-range one goes straight to the result. Fill does one RAM write per
// used byte; find does one byte read per cycle behind the RAM, over at most the used bytes.
// Reset is synchronous; a valid bit per byte makes the whole map read as zero at once,
// with no clearing pass. A result waits in the output register, so m_axis stalls only
// hold a finished command once the register is still full.
`default_nettype none

module bitmap_set_get_find_first_core (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // config: byte_count
    input  wire logic                         i_cfg_we,
    input  wire logic [bmff_pkg::CNT_W-1:0]   i_cfg_wdata,
    // command stream
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // [1:0] action, [10:2] bit_index, [11] bit_value, [15:12] zero
    input  wire logic [bmff_pkg::TDATA_W-1:0] s_axis_tdata,
    // result stream
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [0] accepted, [1] bit_read, [2] first_found, [11:3] first_index, [15:12] zero
    output logic      [bmff_pkg::TDATA_W-1:0] m_axis_tdata
);

    localparam int BYTE_W = bmff_pkg::BYTE_W;
    localparam int ADDR_W = bmff_pkg::ADDR_W;
    localparam int POS_W  = bmff_pkg::POS_W;
    localparam int CNT_W  = bmff_pkg::CNT_W;
    localparam int IDX_W  = bmff_pkg::IDX_W;
    localparam int ACT_W  = bmff_pkg::ACT_W;

    // State and registers
    bmff_pkg::t_state  r_state, n_state;
    bmff_pkg::t_action r_act;
    logic [IDX_W-1:0]  r_idx;
    logic              r_val;
    logic [CNT_W-1:0]  r_used;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_pend;
    logic [ADDR_W-1:0] r_paddr;
    logic [CNT_W-1:0]  r_byte_count;
    logic [bmff_pkg::MAP_BYTES-1:0] r_valid;

    logic              r_res_acc, r_res_rd, r_res_found;
    logic [IDX_W-1:0]  r_res_first;

    logic              r_out_valid;
    logic              r_out_acc, r_out_rd, r_out_found;
    logic [IDX_W-1:0]  r_out_first;

    // Combinational signals
    logic              s_fire, m_fire;
    bmff_pkg::t_action in_act;
    logic [IDX_W-1:0]  in_idx;
    logic              in_val;
    logic [CNT_W-1:0]  used_now;
    logic              in_range;
    logic              cnt_lt;
    logic              out_load;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [BYTE_W-1:0] ram_wdata, ram_rdata;

    logic [BYTE_W-1:0] rmw_byte, rmw_mask, rmw_new, scan_byte;
    bmff_pkg::t_match  scan;
    logic              find_hit, find_miss;

    // Unpack the command beat
    assign in_act   = bmff_pkg::t_action'(s_axis_tdata[ACT_W-1:0]);
    assign in_idx   = s_axis_tdata[ACT_W +: IDX_W];
    assign in_val   = s_axis_tdata[ACT_W + IDX_W];
    assign used_now = (r_byte_count > CNT_W'(bmff_pkg::MAP_BYTES)) ?
                      CNT_W'(bmff_pkg::MAP_BYTES) : r_byte_count;
    assign in_range = {1'b0, in_idx[IDX_W-1:POS_W]} < used_now;

    assign s_axis_tready = (r_state == bmff_pkg::ST_IDLE);
    assign s_fire        = s_axis_tvalid & s_axis_tready;
    assign m_fire        = r_out_valid & m_axis_tready;
    assign out_load      = (r_state == bmff_pkg::ST_DONE) & (~r_out_valid | m_axis_tready);
    assign cnt_lt        = r_cnt < r_used;

    // Byte under modify: never-written bytes read as zero
    assign rmw_byte = r_valid[r_idx[IDX_W-1:POS_W]] ? ram_rdata : '0;
    assign rmw_mask = BYTE_W'(1) << r_idx[POS_W-1:0];
    assign rmw_new  = r_val ? (rmw_byte | rmw_mask) : (rmw_byte & ~rmw_mask);

    // Byte under scan
    assign scan_byte = r_valid[r_paddr] ? ram_rdata : '0;
    assign scan      = bmff_pkg::lowest_match(scan_byte, r_val);
    assign find_hit  = r_pend & scan.hit;
    assign find_miss = ~r_pend & ~cnt_lt;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bmff_pkg::ST_IDLE: begin
                if (s_fire) begin
                    unique case (in_act)
                        bmff_pkg::ACT_FILL:  n_state = bmff_pkg::ST_FILL;
                        bmff_pkg::ACT_FIND:  n_state = bmff_pkg::ST_FIND;
                        bmff_pkg::ACT_WRITE,
                        bmff_pkg::ACT_READ:  n_state = in_range ? bmff_pkg::ST_RMW
                                                                : bmff_pkg::ST_DONE;
                        default:             n_state = bmff_pkg::ST_IDLE;
                    endcase
                end
            end
            bmff_pkg::ST_FILL: begin
                if (!cnt_lt) n_state = bmff_pkg::ST_DONE;
            end
            bmff_pkg::ST_RMW: begin
                n_state = bmff_pkg::ST_DONE;
            end
            bmff_pkg::ST_FIND: begin
                if (find_hit || find_miss) n_state = bmff_pkg::ST_DONE;
            end
            bmff_pkg::ST_DONE: begin
                if (out_load) n_state = bmff_pkg::ST_IDLE;
            end
            default: n_state = bmff_pkg::ST_IDLE;
        endcase
    end

    // RAM port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_cnt[ADDR_W-1:0];
        ram_wdata = {BYTE_W{r_val}};
        ram_raddr = r_cnt[ADDR_W-1:0];
        unique case (r_state)
            bmff_pkg::ST_IDLE: begin
                ram_raddr = in_idx[IDX_W-1:POS_W];
            end
            bmff_pkg::ST_FILL: begin
                ram_we = cnt_lt;
            end
            bmff_pkg::ST_RMW: begin
                ram_we    = (r_act == bmff_pkg::ACT_WRITE);
                ram_waddr = r_idx[IDX_W-1:POS_W];
                ram_wdata = rmw_new;
            end
            bmff_pkg::ST_FIND,
            bmff_pkg::ST_DONE: begin
                ram_we = 1'b0;
            end
            default: ram_we = 1'b0;
        endcase
    end

    bmff_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (bmff_pkg::MAP_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= bmff_pkg::ST_IDLE;
            r_byte_count <= '0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
            r_pend       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_byte_count <= i_cfg_wdata;
            if (ram_we) r_valid[ram_waddr] <= 1'b1;
            r_pend <= (r_state == bmff_pkg::ST_FIND) & cnt_lt;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command, walk pointer and result registers
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_act       <= in_act;
            r_idx       <= in_idx;
            r_val       <= in_val;
            r_used      <= used_now;
            r_cnt       <= '0;
            r_res_acc   <= (in_act == bmff_pkg::ACT_FILL) || (in_act == bmff_pkg::ACT_FIND);
            r_res_rd    <= 1'b0;
            r_res_found <= 1'b0;
            r_res_first <= '0;
        end else begin
            // Advance the walk while bytes remain
            if (((r_state == bmff_pkg::ST_FILL) || (r_state == bmff_pkg::ST_FIND)) && cnt_lt) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (r_state == bmff_pkg::ST_RMW) begin
                r_res_acc <= 1'b1;
                r_res_rd  <= (r_act == bmff_pkg::ACT_READ) & rmw_byte[r_idx[POS_W-1:0]];
            end
            if ((r_state == bmff_pkg::ST_FIND) && find_hit) begin
                r_res_found <= 1'b1;
                r_res_first <= {r_paddr, scan.pos};
            end
        end
        r_paddr <= r_cnt[ADDR_W-1:0];
        if (out_load) begin
            r_out_acc   <= r_res_acc;
            r_out_rd    <= r_res_rd;
            r_out_found <= r_res_found;
            r_out_first <= r_res_first;
        end
    end

    // Pack the result beat
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(bmff_pkg::TDATA_W - IDX_W - 3)'(0),
                            r_out_first, r_out_found, r_out_rd, r_out_acc};

endmodule

`default_nettype wire

>>> hw/rtl/bmff_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module bmff_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/bmff_checker.sv
// Port-level checker for the bitmap core, bound into the core module.
// Depends on bmff_pkg and the assertion macro header.
`default_nettype none
`include "bitmap_set_get_find_first_core_defines.svh"

module bmff_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         s_axis_tvalid,
    input wire logic                         s_axis_tready,
    input wire logic                         m_axis_tvalid,
    input wire logic                         m_axis_tready,
    input wire logic [bmff_pkg::TDATA_W-1:0] m_axis_tdata
);

    // One command in flight: the slave side closes after each beat
    `BMFF_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready,
        "command accepted while another is in flight")

    // A rejected access reports nothing else
    `BMFF_ASSERT_SAME(a_reject_clean, m_axis_tvalid && !m_axis_tdata[0],
        !m_axis_tdata[1] && !m_axis_tdata[2] && (m_axis_tdata[11:3] == 9'd0),
        "rejected result carries data")

    // No match means index zero
    `BMFF_ASSERT_SAME(a_miss_index, m_axis_tvalid && !m_axis_tdata[2],
        m_axis_tdata[11:3] == 9'd0, "find miss with nonzero index")

    // A read and a find result never mix
    `BMFF_ASSERT_SAME(a_read_find_excl, m_axis_tvalid,
        !(m_axis_tdata[1] && m_axis_tdata[2]), "read bit and find hit both set")

    // Stalled result beat holds
    `BMFF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result beat changed under stall")

endmodule

bind bitmap_set_get_find_first_core bmff_checker u_bmff_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
